>>> hdl/plm_pkg.sv
// Shared widths, constants, types and the command and status structs for the peak level meter.
package plm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEVEL_W         = 15;
    localparam int PHASE_W         = 8;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 15;
    localparam int M_TDATA_W       = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 15'd32767;
    localparam logic [LEVEL_W-1:0] SCALE_RESET  = 15'd1200;
    localparam logic [PHASE_W-1:0] PERIOD_RESET = 8'd10;

    // (9*level + peak) fits in 19 bits; /10 done as *419431 >> 22, exact below 2^22/6
    localparam int SUM_W      = 19;
    localparam int SMOOTH_W   = 4;
    localparam logic [SMOOTH_W-1:0] SMOOTH_KEEP = 4'd9;
    localparam int RECIP_W    = 19;
    localparam logic [RECIP_W-1:0] DIV10_RECIP = 19'd419431;
    localparam int DIV10_SHIFT = 22;
    localparam int QPROD_W    = SUM_W + RECIP_W;
    localparam int DUTY_W     = PHASE_W + 1 + LEVEL_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_SCALE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DUTY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic peak_update;
        logic sum_load;
        logic level_load;
        logic duty_load;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> hdl/plm_ctrl.sv
// Sequencing state machine for the peak level meter.
module plm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  plm_pkg::dp_status_t   status,
    output plm_pkg::ctrl_cmd_t    cmd
);

    plm_pkg::state_t state_reg, state_next;
    logic            beat_live;

    assign beat_live = s_tvalid && s_tuser;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plm_pkg::ST_IDLE: begin
                if (beat_live && s_tlast) begin
                    state_next = plm_pkg::ST_SUM;
                end
            end
            plm_pkg::ST_SUM:  state_next = plm_pkg::ST_DIV;
            plm_pkg::ST_DIV:  state_next = plm_pkg::ST_DUTY;
            plm_pkg::ST_DUTY: state_next = plm_pkg::ST_OUT;
            plm_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = plm_pkg::ST_IDLE;
                end
            end
            default: state_next = plm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            plm_pkg::ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.peak_update = beat_live;
            end
            plm_pkg::ST_SUM:  cmd.sum_load   = 1'b1;
            plm_pkg::ST_DIV:  cmd.level_load = 1'b1;
            plm_pkg::ST_DUTY: cmd.duty_load  = 1'b1;
            plm_pkg::ST_OUT:  cmd.out_load   = status.out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/plm_dp.sv
// Datapath: config registers, peak tracker, smoothing, PWM phase and output register.
module plm_dp #(
    parameter int SAMPLE_BITS = plm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [plm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  plm_pkg::ctrl_cmd_t                  cmd,
    output plm_pkg::dp_status_t                 status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [plm_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int EXT_W = (SAMPLE_BITS > plm_pkg::LEVEL_W + 1) ?
                           SAMPLE_BITS : plm_pkg::LEVEL_W + 1;

    logic [plm_pkg::LEVEL_W-1:0] scale_reg;
    logic [plm_pkg::PHASE_W-1:0] period_reg;
    logic [plm_pkg::LEVEL_W-1:0] peak_reg, peak_next;
    logic [plm_pkg::LEVEL_W-1:0] level_reg;
    logic [plm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [plm_pkg::SUM_W-1:0]   sum_reg;
    logic [plm_pkg::DUTY_W-1:0]  duty_reg;
    logic                        m_valid_reg;
    logic [plm_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [EXT_W-1:0]             mag;
    logic [plm_pkg::LEVEL_W-1:0]  sat;
    logic [plm_pkg::QPROD_W-1:0]  qprod;
    logic [plm_pkg::PHASE_W:0]    phase_inc;
    logic [plm_pkg::LEVEL_W-1:0]  scale_eff;
    logic                         lit;

    // negative samples never beat a peak that starts at zero
    always_comb begin
        mag = EXT_W'(sample);
        if (sample[SAMPLE_BITS-1]) begin
            sat = '0;
        end else if (mag > EXT_W'(plm_pkg::LEVEL_MAX)) begin
            sat = plm_pkg::LEVEL_MAX;
        end else begin
            sat = mag[plm_pkg::LEVEL_W-1:0];
        end
        peak_next = (sat > peak_reg) ? sat : peak_reg;
    end

    always_comb begin
        qprod     = plm_pkg::QPROD_W'(sum_reg) * plm_pkg::QPROD_W'(plm_pkg::DIV10_RECIP);
        phase_inc = {1'b0, phase_reg} + 9'd1;
        if (phase_inc >= {1'b0, period_reg}) begin
            phase_next = '0;
        end else begin
            phase_next = phase_inc[plm_pkg::PHASE_W-1:0];
        end
        scale_eff = (scale_reg == '0) ? plm_pkg::LEVEL_W'(1) : scale_reg;
        // level/scale > phase  <=>  level >= (phase + 1) * scale
        lit       = plm_pkg::DUTY_W'(level_reg) >= duty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= plm_pkg::SCALE_RESET;
            period_reg <= plm_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                plm_pkg::CFG_LEVEL_SCALE: scale_reg  <= cfg_data[plm_pkg::LEVEL_W-1:0];
                plm_pkg::CFG_PWM_PERIOD:  period_reg <= cfg_data[plm_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            level_reg <= '0;
            phase_reg <= '0;
        end else begin
            if (cmd.peak_update) begin
                peak_reg <= peak_next;
            end else if (cmd.sum_load) begin
                peak_reg <= '0;
            end
            if (cmd.level_load) begin
                level_reg <= qprod[plm_pkg::DIV10_SHIFT +: plm_pkg::LEVEL_W];
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_load) begin
            sum_reg <= plm_pkg::SUM_W'(level_reg) * plm_pkg::SUM_W'(plm_pkg::SMOOTH_KEEP)
                       + plm_pkg::SUM_W'(peak_reg);
        end
        if (cmd.duty_load) begin
            duty_reg <= plm_pkg::DUTY_W'({1'b0, phase_reg} + 9'd1)
                        * plm_pkg::DUTY_W'(scale_eff);
        end
        if (cmd.out_load) begin
            m_data_reg <= {phase_reg, level_reg, lit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;

endmodule

>>> hdl/peak_level_meter_pwm.sv
// Top level of the peak level meter with PWM indicator output.
// Audio samples stream in one beat each; tlast marks the last sample of a block and
// tuser must be 1 for the beat to count (beats with tuser 0 are taken and dropped).
// A mid-block sample only updates the peak. A block-end sample passes five steps:
// peak update, 9*level + peak, the divide by ten as a reciprocal multiply, the
// duty multiply (phase + 1) * scale, and loading the output register. The three
// multiplies run in sequence and no sample is taken meanwhile. The next block's
// samples are taken while the result still waits in the output register; a
// further block end stalls only if that result has not been taken. One result beat
// per block: level is (9*level+peak)/10; indicator lit when level/level_scale > phase.
// Configuration writes are taken at any time but are meant for when the block is idle.
module peak_level_meter_pwm #(
    parameter  int SAMPLE_BITS = plm_pkg::SAMPLE_BITS_DEF,
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [plm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [plm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_TDATA_W-1:0]              s_tdata,   // sample
    input  logic                              s_tlast,   // block end
    input  logic                              s_tuser,   // streaming
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [plm_pkg::M_TDATA_W-1:0]     m_tdata    // pwm_phase, smoothed_level, indicator_on
);

    plm_pkg::ctrl_cmd_t  cmd;
    plm_pkg::dp_status_t status;

    plm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
